/* design/priority_schedule_calculator_unit_assert.svh */
// assertion macros for the top design file
`ifndef PRIORITY_SCHEDULE_CALCULATOR_UNIT_ASSERT_SVH
`define PRIORITY_SCHEDULE_CALCULATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/psc_pkg.sv */
`default_nettype none
package psc_pkg;

	localparam int unsigned MAX_PROCS = 64;
	localparam int unsigned CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int unsigned TIME_W    = 16;
	localparam int unsigned PRIO_W    = 8;
	localparam int unsigned CLK_W     = 24;
	localparam int unsigned SUM_W     = 32;
	localparam int unsigned COUNT_W   = 7;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] arr;
		logic [TIME_W-1:0] id;
	} proc_rec_t;

	typedef struct packed {
		logic load;
		logic pop;
	} chain_ctl_t;

	typedef struct packed {
		logic             pop;
		logic             final_pop;
		logic [CNT_W-1:0] n;
	} pop_ctl_t;

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} psc_state_t;

	// strict order: priority, then arrival
	function automatic logic goes_before(proc_rec_t x, proc_rec_t y);
		return {x.prio, x.arr} < {y.prio, y.arr};
	endfunction

endpackage
`default_nettype wire

/* design/psc_rec_if.sv */
`default_nettype none
interface psc_rec_if;
	logic                        valid;
	logic                        ready;
	logic [psc_pkg::TIME_W-1:0]  proc_id;
	logic [psc_pkg::TIME_W-1:0]  arr_time;
	logic [psc_pkg::TIME_W-1:0]  run_time;
	logic [psc_pkg::PRIO_W-1:0]  priority_req;
	logic                        last;

	modport source (
		output valid, proc_id, arr_time, run_time, priority_req, last,
		input  ready
	);
	modport sink (
		input  valid, proc_id, arr_time, run_time, priority_req, last,
		output ready
	);
endinterface
`default_nettype wire

/* design/psc_res_if.sv */
`default_nettype none
interface psc_res_if;
	logic                        valid;
	logic                        ready;
	logic [psc_pkg::TIME_W-1:0]  out_proc_id;
	logic [psc_pkg::CLK_W-1:0]   start_time;
	logic [psc_pkg::CLK_W-1:0]   waiting_time;
	logic [psc_pkg::CLK_W-1:0]   turnaround_time;
	logic [psc_pkg::SUM_W-1:0]   total_waiting;
	logic [psc_pkg::SUM_W-1:0]   total_turnaround;
	logic [psc_pkg::COUNT_W-1:0] proc_count;
	logic                        final_res;

	modport source (
		output valid, out_proc_id, start_time, waiting_time, turnaround_time,
			total_waiting, total_turnaround, proc_count, final_res,
		input  ready
	);
	modport sink (
		input  valid, out_proc_id, start_time, waiting_time, turnaround_time,
			total_waiting, total_turnaround, proc_count, final_res,
		output ready
	);
endinterface
`default_nettype wire

/* design/priority_schedule_calculator_unit.sv */
// channel | dir | payload                                             | handshake
// rec     | in  | proc_id, arr_time, run_time, priority_req, last    | valid/ready
// res     | out | out_proc_id, start/waiting/turnaround times, totals,  | valid/ready
//         |     | proc_count, final_res                                |
// loading takes one item per cycle; it enters the sorted cell row at once if a cell is free
// on last, the row shifts one record per cycle to the timing stage unless output stalls
// a set yields one result per stored record, each passing the s1 and output registers
// no item is taken while a set is being emitted; output stalls hold the whole row
// reset clears the control state only; no clearing pass is needed
`default_nettype none
`include "priority_schedule_calculator_unit_assert.svh"
module priority_schedule_calculator_unit (
	input  logic      clk,
	input  logic      arst_n,
	psc_rec_if.sink   rec,
	psc_res_if.source res
);
	import psc_pkg::*;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PROCS);

	psc_state_t  state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] cnt_inc;
	logic        accept;
	logic        room;
	logic        pop;
	logic        adv;
	proc_rec_t   new_rec;
	chain_ctl_t  chain_ctl;
	pop_ctl_t    pop_ctl;
	proc_rec_t   rec_w [MAX_PROCS];
	logic        ins_w [MAX_PROCS];

	assign rec.ready = (state_q == ST_LOAD);
	assign accept    = rec.valid && rec.ready;
	assign room      = cnt_q < FULL_CNT;
	assign cnt_inc   = cnt_q + CNT_W'(room);
	assign pop       = (state_q == ST_EMIT) && adv && (cnt_q != '0);

	assign new_rec.id    = rec.proc_id;
	assign new_rec.arr   = rec.arr_time;
	assign new_rec.burst = rec.run_time;
	assign new_rec.prio  = rec.priority_req;

	assign chain_ctl.load = accept && room;
	assign chain_ctl.pop  = pop;

	assign pop_ctl.pop       = pop;
	assign pop_ctl.final_pop = (cnt_q == CNT_W'(1));
	assign pop_ctl.n         = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			n_q     <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						cnt_q <= cnt_inc;
						if (rec.last) begin
							n_q     <= cnt_inc;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (pop) begin
						cnt_q <= cnt_q - CNT_W'(1);
						if (pop_ctl.final_pop) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
		proc_rec_t prev_rec;
		proc_rec_t next_rec;
		logic      prev_ins;

		if (i == 0) begin : g_first
			assign prev_rec = new_rec;
			assign prev_ins = 1'b0;
		end else begin : g_mid
			assign prev_rec = rec_w[i-1];
			assign prev_ins = ins_w[i-1];
		end

		if (i == MAX_PROCS - 1) begin : g_tail
			assign next_rec = rec_w[i];
		end else begin : g_inner
			assign next_rec = rec_w[i+1];
		end

		psc_cell u_cell (
			.clk      (clk),
			.ctl      (chain_ctl),
			.new_rec  (new_rec),
			.occupied (CNT_W'(i) < cnt_q),
			.prev_ins (prev_ins),
			.prev_rec (prev_rec),
			.next_rec (next_rec),
			.ins      (ins_w[i]),
			.rec      (rec_w[i])
		);
	end

	psc_sched u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pop_ctl),
		.head   (rec_w[0]),
		.adv    (adv),
		.res    (res)
	);

	`PSC_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= FULL_CNT, "record count above capacity")
	`PSC_ASSERT_NOW(a_emit_nonempty, state_q == ST_EMIT, cnt_q != '0, "emitting an empty set")
	`PSC_ASSERT_NEXT(a_final_pop_load, pop && pop_ctl.final_pop,
		state_q == ST_LOAD && cnt_q == '0, "set not closed after final pop")
	`PSC_ASSERT_NEXT(a_full_drop, accept && !room, cnt_q == FULL_CNT,
		"dropped item changed the record count")
endmodule
`default_nettype wire

/* design/psc_cell.sv */
`default_nettype none
module psc_cell (
	input  logic                  clk,
	input  psc_pkg::chain_ctl_t   ctl,
	input  psc_pkg::proc_rec_t    new_rec,
	input  logic                  occupied,
	input  logic                  prev_ins,
	input  psc_pkg::proc_rec_t    prev_rec,
	input  psc_pkg::proc_rec_t    next_rec,
	output logic                  ins,
	output psc_pkg::proc_rec_t    rec
);
	import psc_pkg::*;

	proc_rec_t rec_q;

	// empty cells always take the insertion point
	assign ins = !occupied || goes_before(new_rec, rec_q);
	assign rec = rec_q;

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			priority if (prev_ins) begin
				rec_q <= prev_rec;
			end else if (ins) begin
				rec_q <= new_rec;
			end else begin
				rec_q <= rec_q;
			end
		end else if (ctl.pop) begin
			rec_q <= next_rec;
		end else begin
			rec_q <= rec_q;
		end
	end
endmodule
`default_nettype wire

/* design/psc_sched.sv */
`default_nettype none
module psc_sched (
	input  logic                clk,
	input  logic                arst_n,
	input  psc_pkg::pop_ctl_t   ctl,
	input  psc_pkg::proc_rec_t  head,
	output logic                adv,
	psc_res_if.source           res
);
	import psc_pkg::*;

	logic [CLK_W-1:0]   clock_q;
	logic               vld_s1;
	logic [TIME_W-1:0]  id_s1;
	logic [CLK_W-1:0]   start_s1;
	logic [CLK_W-1:0]   wt_s1;
	logic [CLK_W-1:0]   tt_s1;
	logic [CNT_W-1:0]   n_s1;
	logic               fin_s1;
	logic [SUM_W-1:0]   wsum_q;
	logic [SUM_W-1:0]   tsum_q;
	logic               res_vld_q;
	logic [TIME_W-1:0]  id_q;
	logic [CLK_W-1:0]   start_q;
	logic [CLK_W-1:0]   wt_q;
	logic [CLK_W-1:0]   tt_q;
	logic [SUM_W-1:0]   wtot_q;
	logic [SUM_W-1:0]   ttot_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               final_q;

	logic [CLK_W:0]     diff;
	logic               idle_gap;
	logic [CLK_W-1:0]   start_c;
	logic [CLK_W-1:0]   wt_c;
	logic [CLK_W-1:0]   fin_c;
	logic [CLK_W-1:0]   tt_c;
	logic [SUM_W-1:0]   wsum_nx;
	logic [SUM_W-1:0]   tsum_nx;

	assign adv = !res_vld_q || res.ready;

	// clock idles forward when it is behind the arrival
	assign diff     = {1'b0, clock_q} - (CLK_W + 1)'(head.arr);
	assign idle_gap = diff[CLK_W];
	assign start_c  = idle_gap ? CLK_W'(head.arr) : clock_q;
	assign wt_c     = idle_gap ? '0 : diff[CLK_W-1:0];
	assign fin_c    = start_c + CLK_W'(head.burst);
	assign tt_c     = wt_c + CLK_W'(head.burst);

	assign wsum_nx = wsum_q + SUM_W'(wt_s1);
	assign tsum_nx = tsum_q + SUM_W'(tt_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q   <= '0;
			vld_s1    <= 1'b0;
			wsum_q    <= '0;
			tsum_q    <= '0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= ctl.pop;
			res_vld_q <= vld_s1;
			if (ctl.pop) begin
				clock_q <= ctl.final_pop ? '0 : fin_c;
			end
			if (vld_s1) begin
				wsum_q <= fin_s1 ? '0 : wsum_nx;
				tsum_q <= fin_s1 ? '0 : tsum_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl.pop) begin
			id_s1    <= head.id;
			start_s1 <= start_c;
			wt_s1    <= wt_c;
			tt_s1    <= tt_c;
			n_s1     <= ctl.n;
			fin_s1   <= ctl.final_pop;
		end
		if (adv && vld_s1) begin
			id_q    <= id_s1;
			start_q <= start_s1;
			wt_q    <= wt_s1;
			tt_q    <= tt_s1;
			wtot_q  <= wsum_nx;
			ttot_q  <= tsum_nx;
			cnt_q   <= COUNT_W'(n_s1);
			final_q <= fin_s1;
		end
	end

	assign res.valid            = res_vld_q;
	assign res.out_proc_id      = id_q;
	assign res.start_time       = start_q;
	assign res.waiting_time     = wt_q;
	assign res.turnaround_time  = tt_q;
	assign res.total_waiting    = wtot_q;
	assign res.total_turnaround = ttot_q;
	assign res.proc_count       = cnt_q;
	assign res.final_res        = final_q;
endmodule
`default_nettype wire

/* tb/sv/priority_schedule_calculator_unit_tb.sv */
`default_nettype none
module priority_schedule_calculator_unit_tb;
	import psc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		logic [TIME_W-1:0]  proc_id;
		logic [CLK_W-1:0]   start_t;
		logic [CLK_W-1:0]   wait_t;
		logic [CLK_W-1:0]   turn_t;
		logic [SUM_W-1:0]   wait_total;
		logic [SUM_W-1:0]   turn_total;
		logic [COUNT_W-1:0] count;
		logic               final_flag;
	} sched_slot_t;

	logic clk;
	logic arst_n;

	psc_rec_if rec_ch ();
	psc_res_if res_ch ();

	priority_schedule_calculator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rec    (rec_ch),
		.res    (res_ch)
	);

	proc_rec_t   held_recs [MAX_PROCS];
	int          held_count;
	sched_slot_t pending_slots [$];
	int          err_count;
	int          cycle_cnt;
	int          gap_pct;
	int          stall_pct;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		res_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	function automatic proc_rec_t mk_rec(input logic [15:0] id, input logic [15:0] arr,
			input logic [15:0] burst, input logic [7:0] prio);
		proc_rec_t r;
		r.id = id;
		r.arr = arr;
		r.burst = burst;
		r.prio = prio;
		return r;
	endfunction

	function automatic proc_rec_t rand_rec(input bit narrow);
		proc_rec_t r;
		r.id = TIME_W'($urandom_range(16'hFFFF));
		if (narrow) begin
			r.arr = TIME_W'($urandom_range(20));
			r.burst = TIME_W'($urandom_range(6));
			r.prio = PRIO_W'($urandom_range(3));
		end else begin
			r.arr = TIME_W'($urandom_range(16'hFFFF));
			r.burst = TIME_W'($urandom_range(16'hFFFF));
			r.prio = PRIO_W'($urandom_range(8'hFF));
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
			err_count++;
		end
	endfunction

	// store the record and, on last, work out the whole schedule
	task automatic load_and_schedule(input proc_rec_t r, input logic lst);
		int          order [MAX_PROCS];
		int          n;
		int          i;
		int          j;
		proc_rec_t   cur;
		proc_rec_t   prev;
		logic [CLK_W-1:0] run_clock;
		logic [SUM_W-1:0] wsum;
		logic [SUM_W-1:0] tsum;
		sched_slot_t slot;
		if (held_count < MAX_PROCS) begin
			held_recs[held_count] = r;
			held_count++;
		end
		if (!lst)
			return;
		n = held_count;
		for (i = 0; i < n; i++) begin
			cur = held_recs[i];
			j = i;
			while (j > 0) begin
				prev = held_recs[order[j-1]];
				if (!({cur.prio, cur.arr} < {prev.prio, prev.arr}))
					break;
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		run_clock = '0;
		wsum = '0;
		tsum = '0;
		for (i = 0; i < n; i++) begin
			cur = held_recs[order[i]];
			if (run_clock < CLK_W'(cur.arr))
				run_clock = CLK_W'(cur.arr);
			slot.proc_id = cur.id;
			slot.start_t = run_clock;
			slot.wait_t = run_clock - CLK_W'(cur.arr);
			run_clock = run_clock + CLK_W'(cur.burst);
			slot.turn_t = run_clock - CLK_W'(cur.arr);
			wsum = wsum + SUM_W'(slot.wait_t);
			tsum = tsum + SUM_W'(slot.turn_t);
			slot.wait_total = wsum;
			slot.turn_total = tsum;
			slot.count = COUNT_W'(n);
			slot.final_flag = (i == n - 1);
			pending_slots.push_back(slot);
		end
		held_count = 0;
	endtask

	always @(posedge clk) begin
		sched_slot_t exp_s;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_slots.size() == 0) begin
				$display("%0t: unexpected result item, proc id %0h", $time,
					res_ch.out_proc_id);
				err_count++;
			end else begin
				exp_s = pending_slots.pop_front();
				check_field("out_proc_id", 32'(exp_s.proc_id), 32'(res_ch.out_proc_id));
				check_field("start_time", 32'(exp_s.start_t), 32'(res_ch.start_time));
				check_field("waiting_time", 32'(exp_s.wait_t), 32'(res_ch.waiting_time));
				check_field("turnaround_time", 32'(exp_s.turn_t),
					32'(res_ch.turnaround_time));
				check_field("total_waiting", exp_s.wait_total, res_ch.total_waiting);
				check_field("total_turnaround", exp_s.turn_total, res_ch.total_turnaround);
				check_field("proc_count", 32'(exp_s.count), 32'(res_ch.proc_count));
				check_field("final_res", 32'(exp_s.final_flag), 32'(res_ch.final_res));
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_rec(input proc_rec_t r, input logic lst);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			rec_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rec_ch.valid <= 1'b1;
		rec_ch.proc_id <= r.id;
		rec_ch.arr_time <= r.arr;
		rec_ch.run_time <= r.burst;
		rec_ch.priority_req <= r.prio;
		rec_ch.last <= lst;
		@(posedge clk);
		while (rec_ch.ready !== 1'b1)
			@(posedge clk);
		load_and_schedule(r, lst);
		@(negedge clk);
	endtask

	task automatic send_set(input int n, input bit narrow);
		int i;
		for (i = 0; i < n; i++)
			send_rec(rand_rec(narrow), i == n - 1);
	endtask

	task automatic test_single_process();
		send_rec(mk_rec(16'h0000, 16'h0000, 16'h0000, 8'h00), 1'b1);
		send_rec(mk_rec(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b1);
	endtask

	task automatic test_priority_and_idle();
		send_rec(mk_rec(16'h0001, 16'h0000, 16'hFFFF, 8'hFF), 1'b0);
		send_rec(mk_rec(16'hFFFF, 16'hFFFF, 16'h0000, 8'h00), 1'b0);
		send_rec(mk_rec(16'h0002, 16'd100, 16'd5, 8'h00), 1'b0);
		send_rec(mk_rec(16'h0003, 16'h0000, 16'd3, 8'h01), 1'b0);
		send_rec(mk_rec(16'h0004, 16'd2, 16'h0000, 8'h01), 1'b0);
		send_rec(mk_rec(16'h5555, 16'h7FFF, 16'h8000, 8'h80), 1'b0);
		send_rec(mk_rec(16'hAAAA, 16'h8000, 16'h0001, 8'h7F), 1'b1);
	endtask

	task automatic test_equal_keys();
		send_rec(mk_rec(16'd10, 16'd10, 16'd4, 8'd3), 1'b0);
		send_rec(mk_rec(16'd11, 16'd10, 16'd1, 8'd3), 1'b0);
		send_rec(mk_rec(16'd12, 16'd10, 16'd0, 8'd3), 1'b0);
		send_rec(mk_rec(16'd13, 16'd10, 16'd2, 8'd3), 1'b0);
		send_rec(mk_rec(16'd14, 16'd5, 16'd7, 8'd3), 1'b0);
		send_rec(mk_rec(16'd15, 16'd10, 16'd3, 8'd2), 1'b1);
	endtask

	// exactly full, then two records past capacity with last on the dropped one
	task automatic test_store_full();
		stall_pct = 67;
		send_set(MAX_PROCS, 1'b0);
		send_set(MAX_PROCS + 2, 1'b1);
		stall_pct = 0;
	endtask

	task automatic test_random_sets(input int gap, input int stall, input int items);
		int sent;
		int n;
		sent = 0;
		gap_pct = gap;
		stall_pct = stall;
		while (sent < items) begin
			if ($urandom_range(31) == 0)
				n = $urandom_range(MAX_PROCS + 4, 20);
			else
				n = $urandom_range(8, 1);
			send_set(n, 1'($urandom_range(1)));
			sent += n;
		end
		gap_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		rec_ch.valid = 1'b0;
		rec_ch.proc_id = '0;
		rec_ch.arr_time = '0;
		rec_ch.run_time = '0;
		rec_ch.priority_req = '0;
		rec_ch.last = 1'b0;
		res_ch.ready = 1'b0;
		held_count = 0;
		err_count = 0;
		cycle_cnt = 0;
		gap_pct = 0;
		stall_pct = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_single_process();
		test_priority_and_idle();
		test_equal_keys();
		test_store_full();
		test_random_sets(0, 0, 55);
		test_random_sets(67, 0, 55);
		test_random_sets(0, 67, 55);
		test_random_sets(7, 7, 55);

		rec_ch.valid <= 1'b0;
		while (pending_slots.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
+incdir+design
design/psc_pkg.sv
design/psc_rec_if.sv
design/psc_res_if.sv
design/psc_cell.sv
design/psc_sched.sv
design/priority_schedule_calculator_unit.sv
tb/sv/priority_schedule_calculator_unit_tb.sv
